// File: design/u8v_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
`timescale 1ns / 1ps

package u8v_pkg;

    localparam int ByteW   = 8;
    localparam int CpW     = 21;
    localparam int CountW  = 2;
    localparam int TdataW  = 8;
    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;

    // Register byte addresses, word index held in paddr[2]
    localparam logic [ApbAddrW-1:0] RegPermitControls = 3'h0;

    localparam logic [CpW-1:0] CpMin2     = 21'h000080;
    localparam logic [CpW-1:0] CpMin3     = 21'h000800;
    localparam logic [CpW-1:0] CpMin4     = 21'h010000;
    localparam logic [CpW-1:0] CpMax      = 21'h10ffff;
    localparam logic [CpW-1:0] SurrLow    = 21'h00d800;
    localparam logic [CpW-1:0] SurrHigh   = 21'h00dfff;
    localparam logic [CpW-1:0] C1Low      = 21'h000080;
    localparam logic [CpW-1:0] C1High     = 21'h00009f;

    localparam logic [ByteW-1:0] AsciiTop  = 8'h80;
    localparam logic [ByteW-1:0] CtrlTop   = 8'h20;
    localparam logic [ByteW-1:0] DelByte   = 8'h7f;
    localparam logic [ByteW-1:0] Lead2Low  = 8'hc2;
    localparam logic [ByteW-1:0] Lead2High = 8'hdf;
    localparam logic [ByteW-1:0] Lead3Low  = 8'he0;
    localparam logic [ByteW-1:0] Lead3High = 8'hef;
    localparam logic [ByteW-1:0] Lead4Low  = 8'hf0;
    localparam logic [ByteW-1:0] Lead4High = 8'hf4;

    // Per-string decoder state
    typedef struct packed {
        logic [CountW-1:0] pending;
        logic [CountW-1:0] seq_len;
        logic [CpW-1:0]    acc;
        logic              error;
    } state_t;

    localparam state_t StateClear = '{pending: '0, seq_len: '0, acc: '0, error: 1'b0};

endpackage

// File: design/utf8_stream_validator.sv
// Top level of the UTF-8 stream validator.
//
//  channel   | direction | beat contents
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tdata: data_byte; tuser: byte_present; tlast: last
//  m_axis    | out       | tdata[0]: valid_res, bits 7:1 zero; one beat per string
//  apb       | in/out    | word 0 (byte address 0): permit_controls in bit 0
//
// One input beat per cycle unless a closing beat waits on a held verdict; the
// decoder state update is a single combinational step between the input
// register and the state/result registers, which take the tlast beat's verdict.
// Reset clears the pipeline valids, the decoder state and permit_controls.
// A held m_axis beat stalls only beats with tlast; others drain past it.
`timescale 1ns / 1ps

module utf8_stream_validator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [u8v_pkg::TdataW-1:0]      s_axis_tdata,   // [7:0] data_byte
    input  logic                            s_axis_tuser,   // [0] byte_present
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [u8v_pkg::TdataW-1:0]      m_axis_tdata,   // [0] valid_res, [7:1] zero
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [u8v_pkg::ApbAddrW-1:0]    paddr,
    input  logic [u8v_pkg::ApbDataW-1:0]    pwdata,
    output logic [u8v_pkg::ApbDataW-1:0]    prdata,
    output logic                            pready
);

    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic [u8v_pkg::ByteW-1:0]      in_byte_reg;
    logic                           in_present_reg;
    logic                           in_last_reg;
    u8v_pkg::state_t                state_reg;
    u8v_pkg::state_t                state_next;
    u8v_pkg::state_t                step_state;
    logic                           step_verdict;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_res_reg;
    logic                           permit_controls;
    logic                           in_take;
    logic                           step_fire;

    u8v_apb u_apb
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .permit_controls (permit_controls)
    );

    u8v_step u_step
    (
        .cur             (state_reg),
        .data_byte       (in_byte_reg),
        .byte_present    (in_present_reg),
        .last            (in_last_reg),
        .permit_controls (permit_controls),
        .nxt             (step_state),
        .verdict         (step_verdict)
    );

    // A closing beat needs room in the result register; others always advance
    assign step_fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_fire)
        begin
            in_valid_next = 1'b0;
        end

        state_next = step_fire ? step_state : state_reg;

        out_valid_next = out_valid_reg;
        if (step_fire && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= u8v_pkg::StateClear;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg    <= s_axis_tdata;
            in_present_reg <= s_axis_tuser;
            in_last_reg    <= s_axis_tlast;
        end
        if (step_fire && in_last_reg)
        begin
            out_res_reg <= step_verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(u8v_pkg::TdataW-1){1'b0}}, out_res_reg};

endmodule

// File: design/u8v_step.sv
// Next-state logic of the decoder for one beat.
`timescale 1ns / 1ps

module u8v_step
(
    input  u8v_pkg::state_t              cur,
    input  logic [u8v_pkg::ByteW-1:0]    data_byte,
    input  logic                         byte_present,
    input  logic                         last,
    input  logic                         permit_controls,
    output u8v_pkg::state_t              nxt,
    output logic                         verdict
);

    u8v_pkg::state_t           upd;
    logic [u8v_pkg::CpW-1:0]   acc_shift;
    logic [u8v_pkg::CountW-1:0] pend_dec;
    logic [u8v_pkg::CpW-1:0]   minimum;
    logic                      cp_bad;
    logic                      c1_bad;

    assign acc_shift = {cur.acc[u8v_pkg::CpW-7:0], data_byte[5:0]};
    assign pend_dec  = cur.pending - 2'd1;

    always_comb
    begin
        case (cur.seq_len)
            2'd1:    minimum = u8v_pkg::CpMin2;
            2'd2:    minimum = u8v_pkg::CpMin3;
            default: minimum = u8v_pkg::CpMin4;
        endcase
    end

    assign cp_bad = (acc_shift < minimum) || (acc_shift > u8v_pkg::CpMax) ||
                    ((acc_shift >= u8v_pkg::SurrLow) && (acc_shift <= u8v_pkg::SurrHigh));
    assign c1_bad = !permit_controls &&
                    (acc_shift >= u8v_pkg::C1Low) && (acc_shift <= u8v_pkg::C1High);

    always_comb
    begin
        upd = cur;
        if (byte_present && !cur.error)
        begin
            if (cur.pending == '0)
            begin
                if (data_byte < u8v_pkg::AsciiTop)
                begin
                    if ((data_byte == '0) || (!permit_controls &&
                        ((data_byte < u8v_pkg::CtrlTop) || (data_byte == u8v_pkg::DelByte))))
                    begin
                        upd.error = 1'b1;
                    end
                end
                else if ((data_byte >= u8v_pkg::Lead2Low) && (data_byte <= u8v_pkg::Lead2High))
                begin
                    upd.pending = 2'd1;
                    upd.seq_len = 2'd1;
                    upd.acc     = {16'd0, data_byte[4:0]};
                end
                else if ((data_byte >= u8v_pkg::Lead3Low) && (data_byte <= u8v_pkg::Lead3High))
                begin
                    upd.pending = 2'd2;
                    upd.seq_len = 2'd2;
                    upd.acc     = {17'd0, data_byte[3:0]};
                end
                else if ((data_byte >= u8v_pkg::Lead4Low) && (data_byte <= u8v_pkg::Lead4High))
                begin
                    upd.pending = 2'd3;
                    upd.seq_len = 2'd3;
                    upd.acc     = {18'd0, data_byte[2:0]};
                end
                else
                begin
                    upd.error = 1'b1;
                end
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                upd.error = 1'b1;
            end
            else
            begin
                upd.acc     = acc_shift;
                upd.pending = pend_dec;
                if (pend_dec == '0)
                begin
                    // character complete: range checks, then drop the code point
                    upd.error   = cp_bad || c1_bad;
                    upd.seq_len = '0;
                    upd.acc     = '0;
                end
            end
        end
    end

    assign verdict = !upd.error && (upd.pending == '0);
    assign nxt     = last ? u8v_pkg::StateClear : upd;

endmodule

// File: design/u8v_apb.sv
// Configuration register file on the APB port.
`timescale 1ns / 1ps

module u8v_apb
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [u8v_pkg::ApbAddrW-1:0]    paddr,
    input  logic [u8v_pkg::ApbDataW-1:0]    pwdata,
    output logic [u8v_pkg::ApbDataW-1:0]    prdata,
    output logic                            pready,
    output logic                            permit_controls
);

    logic permit_controls_reg;
    logic permit_controls_next;
    logic sel_permit;

    // Word decode on paddr[2]; low address bits are ignored
    assign sel_permit = (paddr[2] == u8v_pkg::RegPermitControls[2]);

    always_comb
    begin
        permit_controls_next = permit_controls_reg;
        if (psel && penable && pwrite && sel_permit)
        begin
            permit_controls_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            permit_controls_reg <= 1'b0;
        end
        else
        begin
            permit_controls_reg <= permit_controls_next;
        end
    end

    assign prdata          = sel_permit ? {31'd0, permit_controls_reg} : '0;
    assign pready          = 1'b1;
    assign permit_controls = permit_controls_reg;

endmodule

// File: design/u8v_checker.sv
// Port-level checks for the UTF-8 stream validator, bound to the top level.
`timescale 1ns / 1ps

module u8v_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [u8v_pkg::TdataW-1:0]      m_axis_tdata,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [u8v_pkg::ApbAddrW-1:0]    paddr,
    input logic [u8v_pkg::ApbDataW-1:0]    pwdata,
    input logic [u8v_pkg::ApbDataW-1:0]    prdata
);

    // Held verdict beat keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict beat changed while stalled");

    // Only bit 0 of a verdict carries information
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[u8v_pkg::TdataW-1:1] == '0))
        else $error("verdict padding not zero");

    // A fresh verdict is preceded by a closing input beat taken on s_axis
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("verdict without closing beat");

    // Register read-back reflects the last write taken out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n && psel && penable && pwrite &&
              (paddr[2] == u8v_pkg::RegPermitControls[2])) &&
        (paddr[2] == u8v_pkg::RegPermitControls[2])
        |-> (prdata[0] == $past(pwdata[0])))
        else $error("permit_controls read-back mismatch");

endmodule

bind utf8_stream_validator u8v_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
